// ===== rtl/qpht_pkg.sv =====
`timescale 1ns / 1ps

package qpht_pkg;

   localparam int KEY_BITS           = 16;
   localparam int VALUE_BITS         = 32;
   localparam int TABLE_SIZE_DEFAULT = 251;

   typedef enum logic [1:0] {
      OP_SET    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_UPDATED   = 3'd1,
      STATUS_FOUND     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FLAG_EMPTY   = 2'd0,
      FLAG_USED    = 2'd1,
      FLAG_DELETED = 2'd2
   } flag_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HOME_MUL,
      ST_HOME_QUO,
      ST_HOME_REM,
      ST_READ,
      ST_CHECK,
      ST_OUT
   } state_type;

   typedef struct packed {
      op_type                 op;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [VALUE_BITS-1:0]  read_value;
   } rsp_type;

   typedef struct packed {
      flag_type               flag;
      logic [KEY_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]  value;
   } slot_type;

endpackage

// ===== rtl/quadratic_probe_hash_table_core.sv =====
`timescale 1ns / 1ps
// Flow: after accept a request passes HOME_MUL, HOME_QUO and HOME_REM, then
// a READ and CHECK pair per slot probed (P = slots probed, 1 to TABLE_SIZE),
// then OUT; a refused set or an unknown op goes straight to OUT. One word at a
// time; each probe reads and then checks one slot of the slot memory.
// Reset: synchronous; a clearing pass then marks all TABLE_SIZE slots empty,
// one per cycle, with req_stall high for the whole pass.
module quadratic_probe_hash_table_core #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qpht_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qpht_pkg::rsp_type rsp_word
);

   localparam int KEY_BITS = qpht_pkg::KEY_BITS;
   localparam int IDX_W    = $clog2(TABLE_SIZE);
   localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
   // key mod TABLE_SIZE by reciprocal: quotient estimate is exact or one low
   localparam int SHIFT    = KEY_BITS + IDX_W + 1;
   localparam int RECIP_W  = KEY_BITS + 2;
   localparam int PROD1_W  = KEY_BITS + RECIP_W;
   localparam int QUO_W    = PROD1_W - SHIFT;
   localparam int PROD2_W  = QUO_W + IDX_W;
   localparam logic [63:0]        RECIP_FULL = (64'd1 << SHIFT) / 64'(TABLE_SIZE);
   localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
   localparam logic [IDX_W-1:0]   SIZE_Q     = IDX_W'(TABLE_SIZE);
   localparam logic [IDX_W:0]     SIZE_X     = (IDX_W + 1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0]   HALF       = CNT_W'(TABLE_SIZE / 2);

   qpht_pkg::slot_type mem [TABLE_SIZE];

   qpht_pkg::state_type state_ff, state_in;
   qpht_pkg::op_type    op_ff, op_in;
   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [qpht_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [PROD1_W-1:0]  prod1_ff, prod1_in;
   logic [PROD2_W-1:0]  prod2_ff, prod2_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]    iter_ff, iter_in;
   logic [IDX_W-1:0]    free_ff, free_in;
   logic                free_vld_ff, free_vld_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   qpht_pkg::rsp_type   res_ff, res_in;
   qpht_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   qpht_pkg::slot_type  rd_ff;

   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   qpht_pkg::slot_type  mem_wdata;
   logic                rsp_load;
   logic [PROD2_W-1:0]  diff;
   logic [IDX_W:0]      rem;
   logic                hit;
   logic                is_free;
   logic                have_free;
   logic [IDX_W-1:0]    free_slot;

   function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= SIZE_X)
         sum = sum - SIZE_X;
      return sum[IDX_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qpht_pkg::ST_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      prod1_ff    <= prod1_in;
      prod2_ff    <= prod2_in;
      step_ff     <= step_in;
      iter_ff     <= iter_in;
      free_ff     <= free_in;
      free_vld_ff <= free_vld_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign diff      = {1'b0, key_ff} - prod2_ff;
   assign rem       = diff[IDX_W:0];
   assign hit       = (rd_ff.flag == qpht_pkg::FLAG_USED) && (rd_ff.key == key_ff);
   assign is_free   = (rd_ff.flag != qpht_pkg::FLAG_USED);
   assign have_free = free_vld_ff || is_free;
   assign free_slot = free_vld_ff ? free_ff : idx_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      prod1_in    = prod1_ff;
      prod2_in    = prod2_ff;
      idx_in      = idx_ff;
      step_in     = step_ff;
      iter_in     = iter_ff;
      free_in     = free_ff;
      free_vld_in = free_vld_ff;
      count_in    = count_ff;
      res_in      = res_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff;
      mem_wdata   = '{flag: qpht_pkg::FLAG_EMPTY, key: '0, value: '0};
      rsp_load    = 1'b0;
      req_stall   = 1'b1;

      unique case (state_ff)
         qpht_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = qpht_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         qpht_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               op_in    = req_word.op;
               key_in   = req_word.key;
               value_in = req_word.value;
               res_in   = '{status: qpht_pkg::STATUS_NOT_FOUND, read_value: '0};
               case (req_word.op)
                  qpht_pkg::OP_SET: begin
                     if (count_ff > HALF) begin
                        res_in.status = qpht_pkg::STATUS_FULL;
                        state_in      = qpht_pkg::ST_OUT;
                     end else begin
                        state_in = qpht_pkg::ST_HOME_MUL;
                     end
                  end
                  qpht_pkg::OP_GET, qpht_pkg::OP_REMOVE: state_in = qpht_pkg::ST_HOME_MUL;
                  default: state_in = qpht_pkg::ST_OUT;
               endcase
            end
         end
         qpht_pkg::ST_HOME_MUL: begin
            prod1_in = key_ff * RECIP;
            state_in = qpht_pkg::ST_HOME_QUO;
         end
         qpht_pkg::ST_HOME_QUO: begin
            prod2_in = prod1_ff[PROD1_W-1:SHIFT] * SIZE_Q;
            state_in = qpht_pkg::ST_HOME_REM;
         end
         qpht_pkg::ST_HOME_REM: begin
            idx_in      = (rem >= SIZE_X) ? IDX_W'(rem - SIZE_X) : rem[IDX_W-1:0];
            step_in     = IDX_W'(1);
            iter_in     = '0;
            free_vld_in = 1'b0;
            state_in    = qpht_pkg::ST_READ;
         end
         qpht_pkg::ST_READ: begin
            state_in = qpht_pkg::ST_CHECK;
         end
         qpht_pkg::ST_CHECK: begin
            if (hit) begin
               state_in = qpht_pkg::ST_OUT;
               case (op_ff)
                  qpht_pkg::OP_SET: begin
                     mem_we        = 1'b1;
                     mem_wdata     = '{flag: qpht_pkg::FLAG_USED, key: key_ff,
                                       value: value_ff};
                     res_in.status = qpht_pkg::STATUS_UPDATED;
                  end
                  qpht_pkg::OP_GET: begin
                     res_in.status     = qpht_pkg::STATUS_FOUND;
                     res_in.read_value = rd_ff.value;
                  end
                  qpht_pkg::OP_REMOVE: begin
                     mem_we            = 1'b1;
                     mem_wdata         = '{flag: qpht_pkg::FLAG_DELETED, key: rd_ff.key,
                                           value: rd_ff.value};
                     res_in.status     = qpht_pkg::STATUS_FOUND;
                     res_in.read_value = rd_ff.value;
                     if (count_ff != '0)
                        count_in = count_ff - CNT_W'(1);
                  end
                  default: res_in.status = qpht_pkg::STATUS_NOT_FOUND;
               endcase
            end else begin
               if (is_free && !free_vld_ff) begin
                  free_in     = idx_ff;
                  free_vld_in = 1'b1;
               end
               if (rd_ff.flag == qpht_pkg::FLAG_EMPTY || iter_ff == LAST_IDX) begin
                  state_in = qpht_pkg::ST_OUT;
                  if (op_ff == qpht_pkg::OP_SET) begin
                     if (have_free) begin
                        mem_we        = 1'b1;
                        mem_waddr     = free_slot;
                        mem_wdata     = '{flag: qpht_pkg::FLAG_USED, key: key_ff,
                                          value: value_ff};
                        count_in      = count_ff + CNT_W'(1);
                        res_in.status = qpht_pkg::STATUS_INSERTED;
                     end else begin
                        res_in.status = qpht_pkg::STATUS_FULL;
                     end
                  end
               end else begin
                  // advance to home + (i+1)^2 by adding the odd step 2i+1
                  idx_in   = mod_add(idx_ff, step_ff);
                  step_in  = mod_add(step_ff, IDX_W'(2));
                  iter_in  = iter_ff + IDX_W'(1);
                  state_in = qpht_pkg::ST_READ;
               end
            end
         end
         qpht_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = qpht_pkg::ST_IDLE;
            end
         end
         default: state_in = qpht_pkg::ST_IDLE;
      endcase

      rsp_valid_in = (rsp_valid_ff && rsp_stall) || rsp_load;
      rsp_in       = rsp_load ? res_ff : rsp_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== rtl/qpht_checker.sv =====
`timescale 1ns / 1ps

module qpht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input qpht_pkg::req_type req_word,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input qpht_pkg::rsp_type rsp_word
);

   logic [1:0] pending_ff, pending_in;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc)
         pending_in = pending_ff + 2'd1;
      else if (rsp_acc && !req_acc)
         pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> req_stall)
      else $error("request taken while previous word still in work");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without an outstanding request");

   a_one_ahead: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> pending_ff <= 2'd1)
      else $error("more than one response backed up");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != qpht_pkg::STATUS_FOUND |->
         rsp_word.read_value == '0)
      else $error("read value nonzero without a hit");

endmodule

bind quadratic_probe_hash_table_core qpht_checker u_qpht_checker (.*);
